### design/eca_pkg.sv
// shared constants and tables for the euler angle to quaternion converter
`timescale 1ns / 1ps
package eca_pkg;

  localparam int ANGLE_BITS_DEF     = 16;
  localparam int COMPONENT_BITS_DEF = 16;
  localparam int CORDIC_STEPS_DEF   = 16;

  localparam int FRAC      = 30;
  localparam int XW        = 32;
  localparam int ZW        = 34;
  localparam int PW        = 64;
  localparam int SW        = 36;
  localparam logic signed [XW-1:0] GAIN_Q30 = 32'sd652032874;

  localparam logic ORDER_123 = 1'b0;
  localparam logic ORDER_321 = 1'b1;

  function automatic logic [31:0] atan_turn32(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0: v = 32'd536870912;
      5'd1: v = 32'd316933405;
      5'd2: v = 32'd167458907;
      5'd3: v = 32'd85004756;
      5'd4: v = 32'd42667331;
      5'd5: v = 32'd21354465;
      5'd6: v = 32'd10679838;
      5'd7: v = 32'd5340245;
      5'd8: v = 32'd2670163;
      5'd9: v = 32'd1335086;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41721;
      5'd15: v = 32'd20860;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2607;
      5'd19: v = 32'd1303;
      5'd20: v = 32'd651;
      5'd21: v = 32'd325;
      5'd22: v = 32'd162;
      5'd23: v = 32'd81;
      5'd24: v = 32'd40;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd2;
      5'd29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

### design/eca_angle_if.sv
// request channel carrying one angle triple
`timescale 1ns / 1ps
interface eca_angle_if #(
  parameter int AW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [AW-1:0] angle_first;
  logic signed [AW-1:0] angle_second;
  logic signed [AW-1:0] angle_third;

  modport source (output valid, angle_first, angle_second, angle_third, input ready);
  modport sink (input valid, angle_first, angle_second, angle_third, output ready);
endinterface

### design/eca_quat_if.sv
// result channel carrying one quaternion
`timescale 1ns / 1ps
interface eca_quat_if #(
  parameter int CW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] quat_w;
  logic signed [CW-1:0] quat_x;
  logic signed [CW-1:0] quat_y;
  logic signed [CW-1:0] quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

### design/euler_angles_to_quaternion.sv
// accepts one request per cycle while the output is not stalled
// one cordic cell per step plus three combine stages
// the whole pipeline stalls only while a finished result waits at the output
// reset clears the pipeline valid bits and sets rotation order to 1-2-3
// top level of the euler angle to quaternion converter
`timescale 1ns / 1ps
module euler_angles_to_quaternion import eca_pkg::*; #(
  parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
  parameter int CORDIC_STEPS   = CORDIC_STEPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_data_i,
  eca_angle_if.sink   angle_in,
  eca_quat_if.source  quat_out
);

  localparam int DEPTH = CORDIC_STEPS + 3;

  logic                        order_q;
  logic [DEPTH-1:0]            valid_q;
  logic                        adv;
  logic signed [ANGLE_BITS-1:0] h [3];
  logic signed [ANGLE_BITS-1:0] ang [3];
  logic signed [XW-1:0] xs [CORDIC_STEPS+1][3];
  logic signed [XW-1:0] ys [CORDIC_STEPS+1][3];
  logic signed [ZW-1:0] zs [CORDIC_STEPS+1][3];
  logic signed [COMPONENT_BITS-1:0] q [4];

  assign adv = !valid_q[DEPTH-1] || quat_out.ready;
  assign angle_in.ready = adv;

  assign ang[0] = angle_in.angle_first;
  assign ang[1] = angle_in.angle_second;
  assign ang[2] = angle_in.angle_third;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      h[k]     = ang[k] >>> 1;
      xs[0][k] = GAIN_Q30;
      ys[0][k] = '0;
      zs[0][k] = {{(ZW-ANGLE_BITS){h[k][ANGLE_BITS-1]}}, h[k]} <<< (32 - ANGLE_BITS);
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    eca_cordic_cell #(.STEP(i)) u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .x_i   (xs[i]),
      .y_i   (ys[i]),
      .z_i   (zs[i]),
      .x_o   (xs[i+1]),
      .y_o   (ys[i+1]),
      .z_o   (zs[i+1])
    );
  end

  eca_combine #(.CW(COMPONENT_BITS)) u_combine (
    .clk_i   (clk_i),
    .en_i    (adv),
    .order_i (order_q),
    .c_i     (xs[CORDIC_STEPS]),
    .s_i     (ys[CORDIC_STEPS]),
    .q_o     (q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_123;
      valid_q <= '0;
    end else begin
      if (cfg_we_i) begin
        order_q <= cfg_data_i;
      end
      if (adv) begin
        valid_q <= {valid_q[DEPTH-2:0], angle_in.valid};
      end
    end
  end

  assign quat_out.valid  = valid_q[DEPTH-1];
  assign quat_out.quat_w = q[0];
  assign quat_out.quat_x = q[1];
  assign quat_out.quat_y = q[2];
  assign quat_out.quat_z = q[3];

`ifndef SYNTH
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    angle_in.valid && angle_in.ready |=> valid_q[0])
    else $error("accepted request missing from first stage");
  a_idle_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !angle_in.valid |=> !valid_q[0])
    else $error("first stage filled without request");
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(valid_q))
    else $error("pipeline moved during stall");
`endif

endmodule

### design/eca_cordic_cell.sv
// one cordic rotation step for the three half angles
`timescale 1ns / 1ps
module eca_cordic_cell import eca_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [XW-1:0] x_i [3],
  input  logic signed [XW-1:0] y_i [3],
  input  logic signed [ZW-1:0] z_i [3],
  output logic signed [XW-1:0] x_o [3],
  output logic signed [XW-1:0] y_o [3],
  output logic signed [ZW-1:0] z_o [3]
);

  localparam logic signed [ZW-1:0] ATAN =
    signed'({{(ZW-32){1'b0}}, atan_turn32(5'(STEP))});

  logic signed [XW-1:0] x_d [3];
  logic signed [XW-1:0] y_d [3];
  logic signed [ZW-1:0] z_d [3];
  logic signed [XW-1:0] x_q [3];
  logic signed [XW-1:0] y_q [3];
  logic signed [ZW-1:0] z_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!z_i[k][ZW-1]) begin
        x_d[k] = x_i[k] - (y_i[k] >>> STEP);
        y_d[k] = y_i[k] + (x_i[k] >>> STEP);
        z_d[k] = z_i[k] - ATAN;
      end else begin
        x_d[k] = x_i[k] + (y_i[k] >>> STEP);
        y_d[k] = y_i[k] - (x_i[k] >>> STEP);
        z_d[k] = z_i[k] + ATAN;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

### design/eca_combine.sv
// triple products, signed sums, rounding and saturation
`timescale 1ns / 1ps
module eca_combine import eca_pkg::*; #(
  parameter int CW = COMPONENT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic                 order_i,
  input  logic signed [XW-1:0] c_i [3],
  input  logic signed [XW-1:0] s_i [3],
  output logic signed [CW-1:0] q_o [4]
);

  localparam logic signed [SW-1:0] HI = SW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] LO = -HI - SW'(1);
  localparam int SH = FRAC - (CW - 1);

  logic signed [PW-1:0] p1 [4];
  logic signed [PW-1:0] p2 [8];
  logic signed [XW-1:0] pair_q [4];
  logic signed [XW-1:0] c3_q, s3_q;
  logic signed [XW-1:0] t_q [8];
  logic signed [SW-1:0] v [4];
  logic signed [SW-1:0] r [4];
  logic signed [CW-1:0] q_d [4];
  logic signed [CW-1:0] q_q [4];

  // pairs: c1c2, s1s2, s1c2, c1s2
  always_comb begin
    p1[0] = c_i[0] * c_i[1];
    p1[1] = s_i[0] * s_i[1];
    p1[2] = s_i[0] * c_i[1];
    p1[3] = c_i[0] * s_i[1];
  end

  always_comb begin
    p2[0] = pair_q[0] * c3_q;
    p2[1] = pair_q[1] * s3_q;
    p2[2] = pair_q[2] * c3_q;
    p2[3] = pair_q[3] * s3_q;
    p2[4] = pair_q[3] * c3_q;
    p2[5] = pair_q[2] * s3_q;
    p2[6] = pair_q[0] * s3_q;
    p2[7] = pair_q[1] * c3_q;
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      // w and y subtract the cross term in 1-2-3 order
      if (((k == 0) || (k == 2)) ^ (order_i == ORDER_321)) begin
        v[k] = SW'(t_q[2*k]) - SW'(t_q[2*k+1]);
      end else begin
        v[k] = SW'(t_q[2*k]) + SW'(t_q[2*k+1]);
      end
      if (SH > 0) begin
        r[k] = (v[k] + (SW'(1) <<< (SH - 1))) >>> SH;
      end else if (SH == 0) begin
        r[k] = v[k];
      end else begin
        r[k] = v[k] <<< 1;
      end
      if (r[k] > HI) begin
        q_d[k] = HI[CW-1:0];
      end else if (r[k] < LO) begin
        q_d[k] = LO[CW-1:0];
      end else begin
        q_d[k] = r[k][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        pair_q[k] <= p1[k][FRAC+XW-1:FRAC];
        q_q[k]    <= q_d[k];
      end
      c3_q <= c_i[2];
      s3_q <= s_i[2];
      for (int k = 0; k < 8; k++) begin
        t_q[k] <= p2[k][FRAC+XW-1:FRAC];
      end
    end
  end

  assign q_o = q_q;

endmodule

### dv/euler_angles_to_quaternion_tb.sv
// self-checking testbench for the euler angle to quaternion converter
`timescale 1ns / 1ps
module euler_angles_to_quaternion_tb;
  import eca_pkg::*;

  localparam int AB = ANGLE_BITS_DEF;
  localparam int CB = COMPONENT_BITS_DEF;
  localparam int NSTEPS = CORDIC_STEPS_DEF;
  localparam int LATENCY = NSTEPS + 3;
  localparam int RANDOM_ITEMS = 1900;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [CB-1:0] w;
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
  } quat_t;

  class quat_scoreboard;
    quat_t pending_q[$];
    logic order;
    int errors;

    function new();
      order = ORDER_123;
      errors = 0;
    endfunction

    function longint floor_shr(longint v, int s);
      return v >>> s;
    endfunction

    function void half_trig(logic signed [AB-1:0] a, output longint c, output longint s);
      longint h, z, x, y, dx, dy;
      h = floor_shr(longint'(a), 1);
      z = h * (longint'(1) << (32 - AB));
      x = GAIN_Q30;
      y = 0;
      for (int i = 0; i < NSTEPS && i < 32; i++) begin
        dx = floor_shr(y, i);
        dy = floor_shr(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(atan_turn32(i[4:0]));
        end else begin
          x += dx; y -= dy; z += longint'(atan_turn32(i[4:0]));
        end
      end
      c = x;
      s = y;
    endfunction

    function longint triple(longint a, longint b, longint d);
      return floor_shr(floor_shr(a * b, FRAC) * d, FRAC);
    endfunction

    function logic signed [CB-1:0] to_q15(longint v);
      longint r, hi, lo;
      int sh;
      sh = FRAC - (CB - 1);
      r = floor_shr(v + (longint'(1) << (sh - 1)), sh);
      hi = (longint'(1) << (CB - 1)) - 1;
      lo = -hi - 1;
      if (r > hi) r = hi;
      if (r < lo) r = lo;
      return r[CB-1:0];
    endfunction

    function void note_angles(logic signed [AB-1:0] a1, logic signed [AB-1:0] a2,
                              logic signed [AB-1:0] a3);
      longint c1, s1, c2, s2, c3, s3, sg;
      quat_t q;
      half_trig(a1, c1, s1);
      half_trig(a2, c2, s2);
      half_trig(a3, c3, s3);
      sg = (order == ORDER_321) ? -1 : 1;
      q.w = to_q15(triple(c1, c2, c3) - sg * triple(s1, s2, s3));
      q.x = to_q15(triple(s1, c2, c3) + sg * triple(c1, s2, s3));
      q.y = to_q15(triple(c1, s2, c3) - sg * triple(s1, c2, s3));
      q.z = to_q15(triple(c1, c2, s3) + sg * triple(s1, s2, c3));
      pending_q.push_back(q);
    endfunction

    task report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_quat(quat_t got);
      quat_t want;
      if (pending_q.size() == 0) begin
        report("unexpected result", 0, 0);
        return;
      end
      want = pending_q.pop_front();
      if (got.w !== want.w) report("quat_w", got.w, want.w);
      if (got.x !== want.x) report("quat_x", got.x, want.x);
      if (got.y !== want.y) report("quat_y", got.y, want.y);
      if (got.z !== want.z) report("quat_z", got.z, want.z);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_data_i = 1'b0;
  longint cycle_count = 0;
  bit drain_mode = 0;

  eca_angle_if #(.AW(AB)) angle_in ();
  eca_quat_if #(.CW(CB)) quat_out ();

  quat_scoreboard sb = new();

  euler_angles_to_quaternion dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i),
    .angle_in(angle_in.sink), .quat_out(quat_out.source)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    angle_in.valid = 1'b0;
    angle_in.angle_first = '0;
    angle_in.angle_second = '0;
    angle_in.angle_third = '0;
    quat_out.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: stall pattern, sometimes always ready
  int stall_mode = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (quat_out.valid && quat_out.ready)
        sb.check_quat({quat_out.quat_w, quat_out.quat_x, quat_out.quat_y, quat_out.quat_z});
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: quat_out.ready <= 1'b1;
        1: quat_out.ready <= ($urandom_range(0, 3) != 0);
        2: quat_out.ready <= ($urandom_range(0, 1) != 0);
        default: quat_out.ready <= ((cycle_count % 7) < 2);
      endcase
    end
  end

  int gap_left = 0;
  int burst_left = 0;

  task send_angles(logic signed [AB-1:0] a1, logic signed [AB-1:0] a2,
                   logic signed [AB-1:0] a3);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    end
    while (gap_left > 0) begin
      angle_in.valid <= 1'b0;
      @(posedge clk_i);
      gap_left--;
    end
    angle_in.valid <= 1'b1;
    angle_in.angle_first <= a1;
    angle_in.angle_second <= a2;
    angle_in.angle_third <= a3;
    @(posedge clk_i);
    while (!angle_in.ready) @(posedge clk_i);
    sb.note_angles(a1, a2, a3);
    burst_left--;
  endtask

  task settle();
    angle_in.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task write_order(logic o);
    cfg_we_i <= 1'b1;
    cfg_data_i <= o;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.order = o;
    @(posedge clk_i);
  endtask

  function logic signed [AB-1:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return AB'($urandom_range(0, 8) - 4);
      3: return AB'(16'sh4000 + $urandom_range(0, 4) - 2);
      default: return AB'($urandom);
    endcase
  endfunction

  logic signed [AB-1:0] corner[8] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0001,
                                      16'shffff, 16'sh4000, 16'shc000, 16'sh2000};

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int p = 0; p < 4; p++) begin
      if (p > 0) write_order(p[0]);
      if (p < 2) begin
        for (int i = 0; i < 8; i++)
          send_angles(corner[i], corner[(i + 3) % 8], corner[(i + 5) % 8]);
        send_angles(16'sh8000, 16'sh8000, 16'sh8000);
        send_angles(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_angles(16'sh5555, 16'shaaaa, 16'sh1234);
      end
      for (int i = 0; i < RANDOM_ITEMS / 4; i++)
        send_angles(rand_angle(), rand_angle(), rand_angle());
      settle();
    end
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule

### filelist.f
design/eca_pkg.sv
design/eca_angle_if.sv
design/eca_quat_if.sv
design/eca_cordic_cell.sv
design/eca_combine.sv
design/euler_angles_to_quaternion.sv
dv/euler_angles_to_quaternion_tb.sv
